FILE: rtl/core/gxdl_pkg.sv
package gxdl_pkg;

  // What the back end does to a parameter word.
  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_BOTH = 2'd1,
    OP_LOW  = 2'd2
  } op_t;

  localparam logic [7:0] CMD_VTX_16    = 8'h23;
  localparam logic [7:0] CMD_VTX_FIRST = 8'h25;
  localparam logic [7:0] CMD_VTX_LAST  = 8'h27;
  localparam logic [3:0] SHIFT_RESET   = 4'd1;

  typedef struct packed {
    logic       refuse;
    logic [5:0] count;
  } cmd_info_t;

  // One entry of the queue between the parser and the rescaler.
  typedef struct packed {
    logic [31:0] word;
    op_t         op;
    logic        error_seen;
    logic        last;
    logic        stream_ok;
  } item_t;

  function automatic cmd_info_t cmd_info(input logic [7:0] code);
    cmd_info_t info;
    info.refuse = 1'b0;
    info.count  = 6'd0;
    if (code inside {8'h00, 8'h11, 8'h15, 8'h41}) begin
      info.count = 6'd0;
    end else if (code == 8'h1b) begin
      info.count = 6'd3;
    end else if (code == CMD_VTX_16) begin
      info.count = 6'd2;
    end else if (code == 8'h34) begin
      info.count = 6'd32;
    end else if (code inside {8'h24, 8'h28}) begin
      info.refuse = 1'b1;
    end else if (code inside {8'h10, [8'h12:8'h14], [8'h20:8'h2b], [8'h30:8'h33], 8'h40}) begin
      info.count = 6'd1;
    end else begin
      info.refuse = 1'b1;
    end
    return info;
  endfunction

endpackage

FILE: rtl/core/gxdl_if.sv
interface gxdl_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_in;
  logic        last_in;

  modport source (output valid, output word_in, output last_in, input ready);
  modport sink (input valid, input word_in, input last_in, output ready);
endinterface

interface gxdl_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_out;
  logic        error_seen;
  logic        last_out;
  logic        stream_ok;

  modport source (output valid, output word_out, output error_seen, output last_out,
                  output stream_ok, input ready);
  modport sink (input valid, input word_out, input error_seen, input last_out,
                input stream_ok, output ready);
endinterface

FILE: rtl/core/gxdl_front.sv
module gxdl_front (
  input  logic           clk,
  input  logic           rst,
  gxdl_in_if.sink        in_ch,
  input  logic           q_ready,
  output logic           q_valid,
  output gxdl_pkg::item_t q_item
);

  logic [31:0] packed_cmds;
  logic [1:0]  slot;
  logic [5:0]  owed;
  logic [7:0]  active;
  logic        expecting;
  logic        refused;

  logic [31:0] packed_cmds_next;
  logic [1:0]  slot_next;
  logic [5:0]  owed_next;
  logic [7:0]  active_next;
  logic        expecting_next;
  logic        refused_next;

  assign in_ch.ready = q_ready;
  assign q_valid     = in_ch.valid;

  always_comb begin
    logic [5:0]          owed_dec;
    logic [2:0]          first;
    logic                do_adv;
    logic                done;
    gxdl_pkg::cmd_info_t info;
    gxdl_pkg::op_t       op;

    packed_cmds_next = packed_cmds;
    slot_next        = slot;
    owed_next        = owed;
    active_next      = active;
    expecting_next   = expecting;
    refused_next     = refused;
    owed_dec         = owed - 6'd1;
    first            = 3'd0;
    do_adv           = 1'b0;
    done             = 1'b0;
    info             = '0;
    op               = gxdl_pkg::OP_PASS;

    if (!refused) begin
      if (expecting) begin
        packed_cmds_next = in_ch.word_in;
        do_adv           = 1'b1;
      end else begin
        if (active == gxdl_pkg::CMD_VTX_16) begin
          if (owed == 6'd2) begin
            op = gxdl_pkg::OP_BOTH;
          end else if (owed == 6'd1) begin
            op = gxdl_pkg::OP_LOW;
          end
        end else if (active >= gxdl_pkg::CMD_VTX_FIRST && active <= gxdl_pkg::CMD_VTX_LAST) begin
          op = gxdl_pkg::OP_BOTH;
        end
        owed_next = owed_dec;
        if (owed_dec == 6'd0) begin
          do_adv = 1'b1;
          first  = {1'b0, slot} + 3'd1;
        end
      end
    end

    // Find next slot owing parameter beats; skip zero-count codes, stop on refusal.
    if (do_adv) begin
      expecting_next = 1'b1;
      owed_next      = 6'd0;
      for (int k = 0; k < 4; k++) begin
        if (!done && 3'(k) >= first) begin
          info = gxdl_pkg::cmd_info(packed_cmds_next[8*k +: 8]);
          if (info.refuse) begin
            refused_next   = 1'b1;
            expecting_next = 1'b1;
            owed_next      = 6'd0;
            done           = 1'b1;
          end else if (info.count != 6'd0) begin
            active_next    = packed_cmds_next[8*k +: 8];
            owed_next      = info.count;
            slot_next      = 2'(k);
            expecting_next = 1'b0;
            done           = 1'b1;
          end
        end
      end
    end

    if (in_ch.last_in && !refused_next && !expecting_next) begin
      refused_next = 1'b1;
    end

    q_item.word       = in_ch.word_in;
    q_item.op         = op;
    q_item.error_seen = refused_next;
    q_item.last       = in_ch.last_in;
    q_item.stream_ok  = in_ch.last_in && !refused_next;

    // The last beat of a stream returns the parser to its start state.
    if (in_ch.last_in) begin
      packed_cmds_next = 32'd0;
      slot_next        = 2'd0;
      owed_next        = 6'd0;
      active_next      = 8'd0;
      expecting_next   = 1'b1;
      refused_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packed_cmds <= 32'd0;
      slot        <= 2'd0;
      owed        <= 6'd0;
      active      <= 8'd0;
      expecting   <= 1'b1;
      refused     <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      packed_cmds <= packed_cmds_next;
      slot        <= slot_next;
      owed        <= owed_next;
      active      <= active_next;
      expecting   <= expecting_next;
      refused     <= refused_next;
    end
  end

endmodule

FILE: rtl/core/gxdl_queue.sv
module gxdl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  gxdl_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output gxdl_pkg::item_t pop_item
);

  gxdl_pkg::item_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/core/gxdl_back.sv
module gxdl_back (
  input  logic            clk,
  input  logic            rst,
  input  logic [3:0]      shift,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  gxdl_pkg::item_t pop_item,
  gxdl_out_if.source      out_ch
);

  // Signed divide by 2^sh, rounding half away from zero.
  function automatic logic [15:0] scale_half(input logic [15:0] raw, input logic [3:0] sh);
    logic [16:0] mag;
    logic [16:0] half;
    logic [16:0] r;
    logic [16:0] neg_r;
    half  = 17'd1 << (sh - 4'd1);
    mag   = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    r     = (mag + half) >> sh;
    neg_r = 17'd0 - r;
    if (sh == 4'd0) begin
      return raw;
    end
    return raw[15] ? neg_r[15:0] : r[15:0];
  endfunction

  logic [31:0] word_next;
  logic        out_valid;

  assign pop_ready    = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;

  always_comb begin
    case (pop_item.op)
      gxdl_pkg::OP_BOTH: word_next = {scale_half(pop_item.word[31:16], shift),
                                      scale_half(pop_item.word[15:0], shift)};
      gxdl_pkg::OP_LOW:  word_next = {pop_item.word[31:16],
                                      scale_half(pop_item.word[15:0], shift)};
      default:           word_next = pop_item.word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_ready) begin
      out_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      out_ch.word_out   <= word_next;
      out_ch.error_seen <= pop_item.error_seen;
      out_ch.last_out   <= pop_item.last;
      out_ch.stream_ok  <= pop_item.stream_ok;
    end
  end

endmodule

FILE: rtl/core/gx_display_list_vertex_rescale.sv
// Display-list vertex rescaler.
// in_ch carries 32-bit display-list beats (word_in, last_in) with valid/ready.
// A command beat packs four command codes, low byte first; their parameter
// beats follow in slot order. Vertex coordinate halves in parameter beats
// are divided by 2^scale_shift, rounded half away from zero.
// out_ch returns exactly one beat per input beat, in order: the word, the
// sticky error flag, a copy of last, and on the last beat stream_ok.
// cfg_we/cfg_wdata write scale_shift (reset value 1); write it only while
// the block is idle.
// Throughput is one beat per cycle while the receiver takes every beat. An
// accepted input beat goes through the parser into the two-entry queue,
// then through the rescaler into the output register.
// When the receiver stalls, the output register holds and the queue fills;
// in_ch.ready drops once both queue entries are taken.
// Synchronous reset empties the queue and output register and returns the
// parser to the start of a stream.
module gx_display_list_vertex_rescale (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  gxdl_in_if.sink     in_ch,
  gxdl_out_if.source  out_ch
);

  logic            q_push_valid;
  logic            q_push_ready;
  gxdl_pkg::item_t q_push_item;
  logic            q_pop_valid;
  logic            q_pop_ready;
  gxdl_pkg::item_t q_pop_item;
  logic [3:0]      scale_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_shift <= gxdl_pkg::SHIFT_RESET;
    end else if (cfg_we) begin
      scale_shift <= cfg_wdata;
    end
  end

  gxdl_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_ready (q_push_ready),
    .q_valid (q_push_valid),
    .q_item  (q_push_item)
  );

  gxdl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  gxdl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .shift     (scale_shift),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_item  (q_pop_item),
    .out_ch    (out_ch)
  );

  a_ok_means_clean_end: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.stream_ok |-> out_ch.last_out && !out_ch.error_seen)
    else $error("stream_ok set on a beat that is not a clean stream end");

  a_ok_on_clean_queue_end: assert property (@(posedge clk) disable iff (rst)
    q_pop_valid && q_pop_item.last && !q_pop_item.error_seen |-> q_pop_item.stream_ok)
    else $error("clean stream end queued without stream_ok");

  a_pass_after_refusal: assert property (@(posedge clk) disable iff (rst)
    q_push_valid && q_push_ready && !in_ch.last_in && q_push_item.error_seen
    |=> !(q_push_valid && q_push_item.op != gxdl_pkg::OP_PASS))
    else $error("word rescaled after the stream was refused");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> scale_shift == $past(cfg_wdata))
    else $error("scale_shift did not take the written value");

endmodule
